// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define FRPDC_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: %m");

// Antecedent implies consequent in the same cycle.
`define FRPDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Antecedent implies consequent in the next cycle.
`define FRPDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

// ===== hdl/frpdc_pkg.sv =====
// Package: phase codes, register indexes, frame descriptor and CRC-8 helper.
`default_nettype none

package frpdc_pkg;

   localparam logic [7:0] CONFIG_INDEX = 8'hFF;
   localparam logic [7:0] CRC_POLY     = 8'hD5;

   localparam logic CSR_FIRST_HDR  = 1'b0;
   localparam logic CSR_SECOND_HDR = 1'b1;

   typedef enum logic [2:0] {
      PH_HEAD0   = 3'd0,
      PH_HEAD1   = 3'd1,
      PH_INDEX   = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_XOR     = 3'd5,
      PH_CRC     = 3'd6
   } phase_type;

   typedef enum logic {
      BK_FETCH = 1'b0,
      BK_SHOW  = 1'b1
   } back_state_type;

   // One accepted frame waiting for readout.
   typedef struct packed {
      logic       bank;
      logic       kind;
      logic [7:0] index;
      logic [7:0] last_pos;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/framed_packet_receiver_dual_check.sv =====
// Framed packet receiver with XOR and CRC-8 checks: top level.
//
// Input channel req_*: one received byte per transaction (valid/ready).
// Output channel rsp_*: one buffered byte per transaction, the length byte
// first at position 0, then the payload, rsp_last on the final byte.
// Configuration csr_*: csr_index 0 sets the first header byte (reset 0x55),
// index 1 the second (reset 0xAA); write only while the block is idle.
// Input takes one byte per cycle while req_ready is high. The front end
// fills one of two frame buffers in RAM; a frame that passes both checks
// is queued; the readout issues the RAM read as the queue turns non-empty
// and the first byte appears on rsp from the registered read.
// Readout then gives one byte per cycle while rsp_ready is high, a frame of
// length L taking L+1 transactions and a pass through the fetch state
// before the next frame, overlapping with reception of the next frame.
// If rsp stalls, up to two checked frames wait in the buffers; req_ready
// then drops only when a third frame reaches its length byte.
// Synchronous reset clears parser, queue and readout state; buffer contents
// are not cleared and need not be.
`default_nettype none
`include "assert_macros.svh"

module framed_packet_receiver_dual_check #(
   parameter int PAYLOAD_LIMIT = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire [7:0]   csr_wdata,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire [7:0]   req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_frame_kind,
   output logic [7:0]  rsp_row_index,
   output logic [5:0]  rsp_byte_pos,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last
);

   import frpdc_pkg::*;

   localparam int ADDR_W = $clog2(2 * PAYLOAD_LIMIT);

   logic              push, pop;
   desc_type          push_desc, head;
   fifo_status_type   fifo_status;
   logic              ram_we, rd_en;
   logic [ADDR_W-1:0] ram_waddr, rd_addr;
   logic [7:0]        ram_wdata, rd_data;
   logic              wr_bank;

   assign wr_bank = ram_waddr[ADDR_W-1];

   frpdc_front #(.PAYLOAD_LIMIT(PAYLOAD_LIMIT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .fifo_full   (fifo_status.full),
      .push        (push),
      .push_desc   (push_desc),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata)
   );

   frpdc_desc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (fifo_status)
   );

   frpdc_ram #(.WIDTH(8), .DEPTH(2 ** ADDR_W)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   frpdc_back #(.PAYLOAD_LIMIT(PAYLOAD_LIMIT)) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .fifo_status    (fifo_status),
      .pop            (pop),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_row_index  (rsp_row_index),
      .rsp_byte_pos   (rsp_byte_pos),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last       (rsp_last)
   );

   `FRPDC_ASSERT(a_no_push_when_full, clock, reset, !(push && fifo_status.full))
   `FRPDC_ASSERT_IMPL(a_valid_has_frame, clock, reset, rsp_valid, !fifo_status.empty)
   `FRPDC_ASSERT_IMPL(a_bank_disjoint, clock, reset, ram_we && rsp_valid, wr_bank != head.bank)
   `FRPDC_ASSERT_NEXT(a_pop_follows_push, clock, reset, push && fifo_status.empty, !fifo_status.empty)

endmodule

`default_nettype wire

// ===== hdl/frpdc_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module frpdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/frpdc_front.sv =====
// Front end: header hunt, dual check, frame buffer writes and descriptor push.
`default_nettype none

module frpdc_front #(
   parameter int PAYLOAD_LIMIT = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire                               csr_index,
   input  wire [7:0]                         csr_wdata,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [7:0]                         req_rx_byte,
   input  wire                               fifo_full,
   output logic                              push,
   output frpdc_pkg::desc_type               push_desc,
   output logic                              ram_we,
   output logic [$clog2(2*PAYLOAD_LIMIT)-1:0] ram_waddr,
   output logic [7:0]                        ram_wdata
);

   import frpdc_pkg::*;

   localparam int POS_W = $clog2(PAYLOAD_LIMIT);
   localparam int WP_W  = $clog2(PAYLOAD_LIMIT + 1);

   phase_type        phase_ff, phase_in;
   logic [7:0]       rem_ff, rem_in;
   logic [WP_W-1:0]  wp_ff, wp_in;
   logic             kind_ff, kind_in;
   logic [7:0]       idx_ff, idx_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       crc_ff, crc_in;
   logic             bank_ff, bank_in;
   logic [7:0]       hdr0_ff, hdr1_ff;

   logic             accept;
   logic             wp_room;
   logic [POS_W-1:0] wpos;

   assign accept  = req_valid && req_ready;
   assign wp_room = wp_ff < WP_W'(PAYLOAD_LIMIT);

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      wp_in    = wp_ff;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      xor_in   = xor_ff;
      crc_in   = crc_ff;
      bank_in  = bank_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HEAD0: begin
               xor_in = req_rx_byte;
               crc_in = crc8_byte(8'h00, req_rx_byte);
               if (req_rx_byte == hdr0_ff) begin
                  phase_in = PH_HEAD1;
               end
            end
            PH_HEAD1: begin
               xor_in   = xor_ff ^ req_rx_byte;
               crc_in   = crc8_byte(crc_ff, req_rx_byte);
               phase_in = (req_rx_byte == hdr1_ff) ? PH_INDEX : PH_HEAD0;
            end
            PH_INDEX: begin
               xor_in   = xor_ff ^ req_rx_byte;
               crc_in   = crc8_byte(crc_ff, req_rx_byte);
               idx_in   = req_rx_byte;
               kind_in  = (req_rx_byte == CONFIG_INDEX);
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               xor_in = xor_ff ^ req_rx_byte;
               crc_in = crc8_byte(crc_ff, req_rx_byte);
               rem_in = req_rx_byte;
               wp_in  = WP_W'(1);
               priority if ({1'b0, req_rx_byte} >= 9'(PAYLOAD_LIMIT)) begin
                  phase_in = PH_HEAD0;
               end else if (req_rx_byte == 8'h00) begin
                  phase_in = PH_XOR;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               xor_in = xor_ff ^ req_rx_byte;
               crc_in = crc8_byte(crc_ff, req_rx_byte);
               if (wp_room) begin
                  wp_in = wp_ff + WP_W'(1);
               end
               rem_in = rem_ff - 8'd1;
               if (rem_ff <= 8'd1) begin
                  phase_in = PH_XOR;
               end
            end
            PH_XOR: begin
               phase_in = (req_rx_byte == xor_ff) ? PH_CRC : PH_HEAD0;
            end
            PH_CRC: begin
               if (req_rx_byte == crc_ff) begin
                  bank_in = ~bank_ff;
               end
               phase_in = PH_HEAD0;
            end
            default: begin
               phase_in = PH_HEAD0;
            end
         endcase
      end
   end

   always_comb begin
      req_ready = !(fifo_full &&
                    (phase_ff == PH_LENGTH || phase_ff == PH_PAYLOAD || phase_ff == PH_CRC));
      wpos      = (phase_ff == PH_LENGTH) ? '0 : wp_ff[POS_W-1:0];
      ram_we    = accept && (phase_ff == PH_LENGTH || (phase_ff == PH_PAYLOAD && wp_room));
      ram_waddr = {bank_ff, wpos};
      ram_wdata = req_rx_byte;
      push      = accept && (phase_ff == PH_CRC) && (req_rx_byte == crc_ff);
      push_desc.bank     = bank_ff;
      push_desc.kind     = kind_ff;
      push_desc.index    = idx_ff;
      push_desc.last_pos = 8'(wp_ff - WP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD0;
         rem_ff   <= '0;
         wp_ff    <= '0;
         kind_ff  <= 1'b0;
         idx_ff   <= '0;
         xor_ff   <= '0;
         crc_ff   <= '0;
         bank_ff  <= 1'b0;
         hdr0_ff  <= 8'h55;
         hdr1_ff  <= 8'hAA;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         wp_ff    <= wp_in;
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         xor_ff   <= xor_in;
         crc_ff   <= crc_in;
         bank_ff  <= bank_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIRST_HDR:  hdr0_ff <= csr_wdata;
               CSR_SECOND_HDR: hdr1_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/frpdc_desc_fifo.sv =====
// Two-entry descriptor queue between front end and readout.
`default_nettype none

module frpdc_desc_fifo (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           push,
   input  frpdc_pkg::desc_type           push_desc,
   input  wire                           pop,
   output frpdc_pkg::desc_type           head,
   output frpdc_pkg::fifo_status_type    status
);

   import frpdc_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/frpdc_back.sv =====
// Readout: walks a buffered frame out of the RAM, one byte per transaction.
`default_nettype none

module frpdc_back #(
   parameter int PAYLOAD_LIMIT = 64
) (
   input  wire                                clock,
   input  wire                                reset,
   input  frpdc_pkg::desc_type                head,
   input  frpdc_pkg::fifo_status_type         fifo_status,
   output logic                               pop,
   output logic                               rd_en,
   output logic [$clog2(2*PAYLOAD_LIMIT)-1:0] rd_addr,
   input  wire [7:0]                          rd_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic                               rsp_frame_kind,
   output logic [7:0]                         rsp_row_index,
   output logic [5:0]                         rsp_byte_pos,
   output logic [7:0]                         rsp_data_byte,
   output logic                               rsp_last
);

   import frpdc_pkg::*;

   localparam int POS_W = $clog2(PAYLOAD_LIMIT);

   back_state_type state_ff, state_in;
   logic [7:0]     pos_ff, pos_in;
   logic           accept;
   logic           at_last;
   logic [7:0]     rd_pos;

   assign accept  = rsp_valid && rsp_ready;
   assign at_last = (pos_ff == head.last_pos);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      unique case (state_ff)
         BK_FETCH: begin
            if (!fifo_status.empty) begin
               state_in = BK_SHOW;
            end
         end
         BK_SHOW: begin
            if (accept) begin
               if (at_last) begin
                  state_in = BK_FETCH;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 8'd1;
               end
            end
         end
         default: state_in = BK_FETCH;
      endcase
   end

   always_comb begin
      rsp_valid = (state_ff == BK_SHOW);
      pop       = accept && at_last;
      rd_en     = ((state_ff == BK_FETCH) && !fifo_status.empty) || (accept && !at_last);
      rd_pos    = (state_ff == BK_SHOW) ? pos_ff + 8'd1 : pos_ff;
      rd_addr   = {head.bank, rd_pos[POS_W-1:0]};
      rsp_frame_kind = head.kind;
      rsp_row_index  = head.index;
      rsp_byte_pos   = pos_ff[5:0];
      rsp_data_byte  = rd_data;
      rsp_last       = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_FETCH;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== sim/frame_stream_checker.sv =====
// Scoreboard for the framed packet receiver: models the byte parser and checks each output byte.
module frame_stream_checker #(
   parameter int MAX_LEN = 64
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_we,
   input  wire        csr_index,
   input  wire [7:0]  csr_wdata,
   input  wire        req_valid,
   input  wire        req_ready,
   input  wire [7:0]  req_rx_byte,
   input  wire        rsp_valid,
   input  wire        rsp_ready,
   input  wire        rsp_frame_kind,
   input  wire [7:0]  rsp_row_index,
   input  wire [5:0]  rsp_byte_pos,
   input  wire [7:0]  rsp_data_byte,
   input  wire        rsp_last,
   output int         mismatch_count,
   output int         bytes_pending,
   output int         bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import frpdc_pkg::*;

   localparam logic [7:0] RST_FIRST_HDR  = 8'h55;
   localparam logic [7:0] RST_SECOND_HDR = 8'hAA;

   typedef struct {
      logic       kind;
      logic [7:0] index;
      logic [5:0] pos;
      logic [7:0] data;
      logic       last;
   } out_byte_type;

   out_byte_type expected_bytes[$];

   phase_type                 phase;
   logic [7:0]                len_left;
   logic [$clog2(MAX_LEN):0]  fill_ptr;
   logic                      cfg_frame;
   logic [7:0]                frame_idx;
   logic [7:0]                xor_sum;
   logic [7:0]                crc_sum;
   logic [7:0]                hdr_first;
   logic [7:0]                hdr_second;
   logic [7:0]                frame_buf [MAX_LEN];

   // CRC-8, MSB first, one input bit at a time
   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[7] ^ b[k];
         r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] frame check: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic fold_sums(input logic [7:0] b);
      xor_sum = xor_sum ^ b;
      crc_sum = crc_fold(crc_sum, b);
   endtask

   task automatic keep_byte(input logic [7:0] b);
      if (fill_ptr < MAX_LEN) begin
         frame_buf[fill_ptr] = b;
         fill_ptr++;
      end
   endtask

   task automatic take_byte(input logic [7:0] b);
      out_byte_type e;
      unique case (phase)
         PH_HEAD0: begin
            xor_sum = 8'h00;
            crc_sum = 8'h00;
            fold_sums(b);
            if (b == hdr_first) phase = PH_HEAD1;
         end
         PH_HEAD1: begin
            fold_sums(b);
            if (b == hdr_second) phase = PH_INDEX;
            else phase = PH_HEAD0;
         end
         PH_INDEX: begin
            fold_sums(b);
            frame_idx = b;
            cfg_frame = (b == CONFIG_INDEX);
            phase     = PH_LENGTH;
         end
         PH_LENGTH: begin
            fold_sums(b);
            len_left = b;
            if (b >= MAX_LEN) phase = PH_HEAD0;
            else if (b == 8'h00) phase = PH_XOR;
            else phase = PH_PAYLOAD;
            fill_ptr = '0;
            keep_byte(b);
         end
         PH_PAYLOAD: begin
            fold_sums(b);
            keep_byte(b);
            if (len_left > 0) len_left--;
            if (len_left == 0) phase = PH_XOR;
         end
         PH_XOR: begin
            if (b == xor_sum) phase = PH_CRC;
            else phase = PH_HEAD0;
         end
         PH_CRC: begin
            if (b == crc_sum) begin
               for (int i = 0; i < fill_ptr; i++) begin
                  e.kind  = cfg_frame;
                  e.index = frame_idx;
                  e.pos   = 6'(i);
                  e.data  = frame_buf[i];
                  e.last  = (i + 1 == fill_ptr);
                  expected_bytes.push_back(e);
               end
            end
            phase = PH_HEAD0;
         end
         default: phase = PH_HEAD0;
      endcase
   endtask

   task automatic check_response();
      out_byte_type e;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected output byte pos %0d data %h",
                                   rsp_byte_pos, rsp_data_byte));
      end else begin
         e = expected_bytes.pop_front();
         if (rsp_frame_kind !== e.kind)
            report_mismatch($sformatf("pos %0d frame_kind got %b expected %b",
                                      e.pos, rsp_frame_kind, e.kind));
         if (rsp_row_index !== e.index)
            report_mismatch($sformatf("pos %0d row_index got %h expected %h",
                                      e.pos, rsp_row_index, e.index));
         if (rsp_byte_pos !== e.pos)
            report_mismatch($sformatf("byte_pos got %0d expected %0d", rsp_byte_pos, e.pos));
         if (rsp_data_byte !== e.data)
            report_mismatch($sformatf("pos %0d data_byte got %h expected %h",
                                      e.pos, rsp_data_byte, e.data));
         if (rsp_last !== e.last)
            report_mismatch($sformatf("pos %0d last got %b expected %b",
                                      e.pos, rsp_last, e.last));
      end
      bytes_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase      = PH_HEAD0;
         len_left   = '0;
         fill_ptr   = '0;
         cfg_frame  = 1'b0;
         frame_idx  = '0;
         xor_sum    = '0;
         crc_sum    = '0;
         hdr_first  = RST_FIRST_HDR;
         hdr_second = RST_SECOND_HDR;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_response();
         if (csr_we) begin
            if (csr_index == CSR_FIRST_HDR) hdr_first = csr_wdata;
            else hdr_second = csr_wdata;
         end
         if (req_valid && req_ready) take_byte(req_rx_byte);
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

// ===== sim/framed_packet_receiver_dual_check_tb.sv =====
// Testbench top: clock, reset, frame stimulus, output back-pressure and the final verdict.
module framed_packet_receiver_dual_check_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import frpdc_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 600;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PHASE_BYTES    = 50;

   typedef enum {
      FR_GOOD,
      FR_BAD_XOR,
      FR_BAD_CRC,
      FR_BAD_HEAD,
      FR_OVERSIZE
   } frame_shape_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_frame_kind;
   logic [7:0] rsp_row_index;
   logic [5:0] rsp_byte_pos;
   logic [7:0] rsp_data_byte;
   logic       rsp_last;

   int mismatch_count;
   int bytes_pending;
   int bytes_checked;

   logic [7:0] hdr_first_val;
   logic [7:0] hdr_second_val;
   bit         req_gaps_on;
   bit         rsp_gaps_on;
   bit         hold_request;
   bit         hold_done;
   int         bytes_sent;
   int         frames_sent;
   int         good_frames;
   int         csr_writes;
   int         quiet_cycles;
   int         input_stall_cycles;

   framed_packet_receiver_dual_check dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_row_index  (rsp_row_index),
      .rsp_byte_pos   (rsp_byte_pos),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last       (rsp_last)
   );

   frame_stream_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_row_index  (rsp_row_index),
      .rsp_byte_pos   (rsp_byte_pos),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && req_valid && !req_ready) input_stall_cycles <= input_stall_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("framed_packet_receiver_dual_check_tb: errors");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_frame(input frame_shape_type shape, input logic [7:0] index,
                             input logic [7:0] len);
      logic [7:0] seq[$];
      logic [7:0] x;
      logic [7:0] c;
      seq.push_back(hdr_first_val);
      if (shape == FR_BAD_HEAD) seq.push_back(hdr_second_val ^ 8'($urandom_range(1, 255)));
      else seq.push_back(hdr_second_val);
      seq.push_back(index);
      seq.push_back(len);
      if (shape != FR_OVERSIZE) begin
         for (int i = 0; i < len; i++) seq.push_back(8'($urandom_range(0, 255)));
         x = 8'h00;
         c = 8'h00;
         foreach (seq[i]) begin
            x = x ^ seq[i];
            c = crc8_byte(c, seq[i]);
         end
         if (shape == FR_BAD_XOR) x = x ^ 8'($urandom_range(1, 255));
         if (shape == FR_BAD_CRC) c = c ^ 8'($urandom_range(1, 255));
         seq.push_back(x);
         seq.push_back(c);
      end
      foreach (seq[i]) send_byte(seq[i]);
      frames_sent++;
      if (shape == FR_GOOD) good_frames++;
   endtask

   task automatic run_phase(input int target);
      int         start;
      int         pick;
      int         r;
      logic [7:0] len;
      logic [7:0] idx;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         pick = $urandom_range(0, 99);
         r    = $urandom_range(0, 19);
         if (r == 0) len = 8'd0;
         else if (r == 1) len = 8'd63;
         else if (r == 2) len = 8'd1;
         else len = 8'($urandom_range(2, 12));
         if ($urandom_range(0, 3) == 0) idx = CONFIG_INDEX;
         else idx = 8'($urandom_range(0, 255));
         if (pick < 70) begin
            send_frame(FR_GOOD, idx, len);
         end else if (pick < 77) begin
            send_frame(FR_BAD_XOR, idx, len);
         end else if (pick < 84) begin
            send_frame(FR_BAD_CRC, idx, len);
         end else if (pick < 90) begin
            send_frame(FR_BAD_HEAD, idx, len);
         end else if (pick < 95) begin
            send_frame(FR_OVERSIZE, idx, 8'($urandom_range(64, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // wait for the output to drain, then let the pipeline go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (bytes_pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_FIRST_HDR) hdr_first_val = value;
      else hdr_second_val = value;
      csr_writes++;
   endtask

   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         if (hold_request && !hold_done) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         stall = rsp_gaps_on ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : req_side
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_FIRST_HDR;
      csr_wdata      = 8'h00;
      req_valid      = 1'b0;
      req_rx_byte    = 8'h00;
      hdr_first_val  = 8'h55;
      hdr_second_val = 8'hAA;
      req_gaps_on    = 1'b1;
      rsp_gaps_on    = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      // wrong second header byte that equals the first header byte
      send_byte(hdr_first_val);
      send_byte(~hdr_second_val);
      send_frame(FR_GOOD, CONFIG_INDEX, 8'd0);
      send_frame(FR_OVERSIZE, 8'h00, 8'd64);
      send_frame(FR_BAD_XOR, 8'h00, 8'd0);
      send_frame(FR_BAD_CRC, 8'h7F, 8'd1);
      run_phase(PHASE_BYTES);

      settle();
      write_csr(CSR_FIRST_HDR, 8'h00);
      write_csr(CSR_SECOND_HDR, 8'hFF);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      run_phase(PHASE_BYTES);

      settle();
      write_csr(CSR_FIRST_HDR, 8'hFF);
      write_csr(CSR_SECOND_HDR, 8'h00);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b0;
      run_phase(PHASE_BYTES);

      settle();
      write_csr(CSR_FIRST_HDR, 8'($urandom_range(0, 255)));
      write_csr(CSR_SECOND_HDR, 8'($urandom_range(0, 255)));
      req_gaps_on  = 1'b0;
      rsp_gaps_on  = 1'b1;
      hold_request = 1'b1;
      repeat (6) send_frame(FR_GOOD, 8'($urandom_range(0, 255)), 8'($urandom_range(20, 40)));
      run_phase(PHASE_BYTES);

      settle();
      write_csr(CSR_FIRST_HDR, 8'h55);
      write_csr(CSR_SECOND_HDR, 8'hAA);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b1;
      run_phase(PHASE_BYTES);

      settle();
      $display("sent %0d bytes in %0d frames (%0d well formed), %0d header register writes",
               bytes_sent, frames_sent, good_frames, csr_writes);
      $display("checked %0d output bytes; input held off for %0d cycles under back-pressure",
               bytes_checked, input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("framed_packet_receiver_dual_check_tb: clean");
      end else begin
         $display("framed_packet_receiver_dual_check_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/frpdc_pkg.sv
hdl/frpdc_ram.sv
hdl/frpdc_front.sv
hdl/frpdc_desc_fifo.sv
hdl/frpdc_back.sv
hdl/framed_packet_receiver_dual_check.sv
sim/frame_stream_checker.sv
sim/framed_packet_receiver_dual_check_tb.sv
